FILE: rtl/core/bcd_calendar_rtc_port_defines.svh
// ----------------------------------------------------------------------------
// BCD calendar RTC port - assertion macros
// Shared concurrent assertion templates, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BCD_CALENDAR_RTC_PORT_DEFINES_SVH
`define BCD_CALENDAR_RTC_PORT_DEFINES_SVH

// same-cycle implication
`define BCRTC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BCRTC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/bcrtc_pkg.sv
// ----------------------------------------------------------------------------
// BCD calendar RTC - shared package
// Port addresses, command codes, time record type and the BCD step function.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bcrtc_pkg;

    localparam logic [7:0]  PORT_CMD       = 8'hCA;
    localparam logic [7:0]  PORT_DATA      = 8'hCB;
    localparam logic [4:0]  CMD_READ_TIME  = 5'h15;
    localparam logic [4:0]  CMD_WRITE_TIME = 5'h14;
    localparam logic [4:0]  CMD_MASK       = 5'h1F;
    localparam logic [7:0]  READ_FLAG      = 8'h80;

    localparam logic [1:0]  FUNC_WRITE     = 2'd0;
    localparam logic [1:0]  FUNC_READ      = 2'd1;
    localparam logic [1:0]  FUNC_TICK      = 2'd2;

    localparam int          ACC_W          = 22;
    localparam int          CYC_W          = 16;
    localparam logic [ACC_W-1:0] ACC_MAX       = 22'h3FFFFF;
    localparam logic [ACC_W-1:0] DIVISOR_RESET = 22'd3072000;

    localparam logic [2:0]  XFER_LEN       = 3'd7;

    typedef struct packed {
        logic [7:0] year;
        logic [7:0] month;
        logic [7:0] mday;
        logic [7:0] wday;
        logic [7:0] hours;
        logic [7:0] minutes;
        logic [7:0] seconds;
    } rtc_time_t;

    // {wrapped, new value}
    function automatic logic [8:0] bcd_step(input logic [7:0] v, input logic [7:0] limit,
                                            input logic [7:0] wrap_to);
        logic [7:0] x;
        logic [3:0] lo;
        logic [3:0] hi;
        lo = v[3:0] + 4'd1;
        hi = v[7:4];
        x  = {hi, lo};
        if (lo >= 4'hA)
        begin
            hi = v[7:4] + 4'd1;
            x  = (hi >= 4'hA) ? 8'h00 : {hi, 4'h0};
        end
        if (x >= limit)
            bcd_step = {1'b1, wrap_to};
        else
            bcd_step = {1'b0, x};
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/bcrtc_calendar.sv
// ----------------------------------------------------------------------------
// BCD calendar RTC - prescaler and calendar
// Holds the time and the prescaler; one tick may advance the time one second.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcrtc_calendar
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wen,
    input  wire logic [bcrtc_pkg::ACC_W-1:0]    cfg_wdata,
    input  wire logic                           tick,
    input  wire logic [bcrtc_pkg::CYC_W-1:0]    cycles,
    output bcrtc_pkg::rtc_time_t                now,
    output logic                                second
);

    logic [bcrtc_pkg::ACC_W-1:0] cps_reg;
    logic [bcrtc_pkg::ACC_W-1:0] acc_reg;
    logic [bcrtc_pkg::ACC_W-1:0] acc_next;
    bcrtc_pkg::rtc_time_t        time_reg;
    bcrtc_pkg::rtc_time_t        time_next;

    logic [bcrtc_pkg::ACC_W:0]   sum;
    logic [bcrtc_pkg::ACC_W:0]   rem;
    logic [8:0] st_sec, st_min, st_hour, st_wday, st_mday, st_mon, st_year;
    logic [7:0] dlimit;
    logic [1:0] leap_want;

    assign sum    = {1'b0, acc_reg} + {{(bcrtc_pkg::ACC_W+1-bcrtc_pkg::CYC_W){1'b0}}, cycles};
    assign second = tick && (sum >= {1'b0, cps_reg});
    assign rem    = second ? (sum - {1'b0, cps_reg}) : sum;

    always_comb
    begin
        leap_want = time_reg.year[4] ? 2'd2 : 2'd0;
        dlimit    = 8'h32;
        if (time_reg.month == 8'h01)
            dlimit = (time_reg.year[1:0] == leap_want) ? 8'h30 : 8'h29;
        else if (time_reg.month == 8'h03 || time_reg.month == 8'h05 ||
                 time_reg.month == 8'h08 || time_reg.month == 8'h10)
            dlimit = 8'h31;

        st_sec  = bcrtc_pkg::bcd_step(time_reg.seconds, 8'h60, 8'h00);
        st_min  = bcrtc_pkg::bcd_step(time_reg.minutes, 8'h60, 8'h00);
        st_hour = bcrtc_pkg::bcd_step(time_reg.hours,   8'h24, 8'h00);
        st_wday = bcrtc_pkg::bcd_step(time_reg.wday,    8'h07, 8'h00);
        st_mday = bcrtc_pkg::bcd_step(time_reg.mday,    dlimit, 8'h01);
        st_mon  = bcrtc_pkg::bcd_step(time_reg.month,   8'h12, 8'h00);
        st_year = bcrtc_pkg::bcd_step(time_reg.year,    8'hA0, 8'h00);

        time_next = time_reg;
        if (second)
        begin
            time_next.seconds = st_sec[7:0];
            if (st_sec[8])
            begin
                time_next.minutes = st_min[7:0];
                if (st_min[8])
                begin
                    time_next.hours = st_hour[7:0];
                    if (st_hour[8])
                    begin
                        time_next.wday = st_wday[7:0];
                        time_next.mday = st_mday[7:0];
                        if (st_mday[8])
                        begin
                            time_next.month = st_mon[7:0];
                            if (st_mon[8])
                                time_next.year = st_year[7:0];
                        end
                    end
                end
            end
        end

        acc_next = acc_reg;
        if (tick)
            acc_next = rem[bcrtc_pkg::ACC_W] ? bcrtc_pkg::ACC_MAX : rem[bcrtc_pkg::ACC_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cps_reg  <= bcrtc_pkg::DIVISOR_RESET;
            acc_reg  <= '0;
            time_reg <= '{year: 8'h00, month: 8'h00, mday: 8'h01, wday: 8'h00,
                          hours: 8'h00, minutes: 8'h00, seconds: 8'h00};
        end
        else
        begin
            if (cfg_wen)
                cps_reg <= cfg_wdata;
            acc_reg  <= acc_next;
            time_reg <= time_next;
        end
    end

    assign now = time_reg;

endmodule

`default_nettype wire

FILE: rtl/core/bcd_calendar_rtc_port.sv
// ----------------------------------------------------------------------------
// BCD calendar RTC port - top level
// Command/data byte ports and a tick input in front of a BCD clock calendar.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                                   | tuser
//  s_*      | in  | [7:0] addr, [15:8] write_data,          | [1:0] func, [2] peek
//           |     | [31:16] cycles                          |
//  m_*      | out | [7:0] read_data                         | [0] second_elapsed
//  cfg_*    | in  | cfg_wdata[21:0] cycles_per_second       | -
//
//  One beat per clock while the output is not stalled.
//  Each beat is latched, then decoded and applied to the state while
//  its result is loaded into the output register.
//  A stalled output holds the input register; reset gives the calendar
//  01 January year 00, 00:00:00 and an empty transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcd_calendar_rtc_port
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // addr, write_data, cycles
    input  wire logic [2:0]  s_tuser,   // func, peek
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // read_data
    output logic [0:0]       m_tuser,   // second_elapsed
    input  wire logic        cfg_wen,
    input  wire logic [21:0] cfg_wdata
);

    logic                      in_valid_reg;
    logic [1:0]                func_reg;
    logic [7:0]                addr_reg;
    logic [7:0]                wdata_reg;
    logic [15:0]               cycles_reg;
    logic                      peek_reg;

    logic                      out_valid_reg;
    logic [7:0]                rdata_reg;
    logic                      sec_reg;
    logic [7:0]                rdata_next;

    logic [4:0]                cmd_reg;
    logic [4:0]                cmd_next;
    logic [2:0]                idx_reg;
    logic [2:0]                idx_next;
    logic [2:0]                cnt_reg;
    logic [2:0]                cnt_next;
    logic [7:0]                xfer_mem [0:6];

    logic                      proc;
    logic                      tick;
    logic                      second;
    logic                      xfer_live;
    logic                      snap;
    logic                      data_wr;
    bcrtc_pkg::rtc_time_t      now;

    assign proc     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || proc;
    assign tick     = proc && (func_reg == bcrtc_pkg::FUNC_TICK);

    bcrtc_calendar u_calendar
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .tick      (tick),
        .cycles    (cycles_reg),
        .now       (now),
        .second    (second)
    );

    assign xfer_live = (idx_reg < cnt_reg) && (idx_reg < bcrtc_pkg::XFER_LEN);

    always_comb
    begin
        cmd_next   = cmd_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        rdata_next = 8'h00;
        snap       = 1'b0;
        data_wr    = 1'b0;
        case (func_reg)
            bcrtc_pkg::FUNC_WRITE:
            begin
                if (addr_reg == bcrtc_pkg::PORT_CMD)
                begin
                    cmd_next = wdata_reg[4:0] & bcrtc_pkg::CMD_MASK;
                    if (cmd_next == bcrtc_pkg::CMD_READ_TIME ||
                        cmd_next == bcrtc_pkg::CMD_WRITE_TIME)
                    begin
                        idx_next = 3'd0;
                        cnt_next = bcrtc_pkg::XFER_LEN;
                        snap     = (cmd_next == bcrtc_pkg::CMD_READ_TIME);
                    end
                end
                else if (addr_reg == bcrtc_pkg::PORT_DATA)
                begin
                    if (cmd_reg == bcrtc_pkg::CMD_WRITE_TIME && xfer_live)
                    begin
                        data_wr  = 1'b1;
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            bcrtc_pkg::FUNC_READ:
            begin
                if (addr_reg == bcrtc_pkg::PORT_CMD)
                    rdata_next = {3'b000, cmd_reg} | bcrtc_pkg::READ_FLAG;
                else if (addr_reg == bcrtc_pkg::PORT_DATA)
                begin
                    rdata_next = bcrtc_pkg::READ_FLAG;
                    if (cmd_reg == bcrtc_pkg::CMD_READ_TIME && xfer_live)
                    begin
                        rdata_next = xfer_mem[idx_reg];
                        if (!peek_reg)
                            idx_next = idx_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                rdata_next = 8'h00;
            end
        endcase
    end

    // transfer buffer: undefined until written, no reset
    always_ff @(posedge clk)
    begin
        if (proc && snap)
        begin
            xfer_mem[0] <= now.year;
            xfer_mem[1] <= now.month;
            xfer_mem[2] <= now.mday;
            xfer_mem[3] <= now.wday;
            xfer_mem[4] <= now.hours;
            xfer_mem[5] <= now.minutes;
            xfer_mem[6] <= now.seconds;
        end
        else if (proc && data_wr)
            xfer_mem[idx_reg] <= wdata_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cmd_reg       <= '0;
            idx_reg       <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (proc)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            if (proc)
            begin
                cmd_reg <= cmd_next;
                idx_reg <= idx_next;
                cnt_reg <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            addr_reg   <= s_tdata[7:0];
            wdata_reg  <= s_tdata[15:8];
            cycles_reg <= s_tdata[31:16];
            func_reg   <= s_tuser[1:0];
            peek_reg   <= s_tuser[2];
        end
        if (proc)
        begin
            rdata_reg <= rdata_next;
            sec_reg   <= second;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = rdata_reg;
    assign m_tuser  = sec_reg;

endmodule

`default_nettype wire

FILE: rtl/core/bcrtc_checker.sv
// ----------------------------------------------------------------------------
// BCD calendar RTC port - port checker
// Watches the top-level ports over time; bound to every instance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "bcd_calendar_rtc_port_defines.svh"

module bcrtc_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [31:0] s_tdata,
    input wire logic [2:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [7:0]  m_tdata,
    input wire logic [0:0]  m_tuser,
    input wire logic        cfg_wen,
    input wire logic [21:0] cfg_wdata
);

    logic unused_ok;
    assign unused_ok = s_tvalid ^ (^s_tdata) ^ (^s_tuser) ^ cfg_wen ^ (^cfg_wdata);

    `BCRTC_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")
    `BCRTC_ASSERT_IMP(a_sec_no_data, m_tvalid && m_tuser[0], m_tdata == 8'h00, "second flag with read data")
    `BCRTC_ASSERT_IMP(a_ready_when_empty, !m_tvalid, s_tready, "input stalled with empty output")

endmodule

bind bcd_calendar_rtc_port bcrtc_checker u_bcrtc_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
);

`default_nettype wire

FILE: test/tb_bcd_calendar_rtc_port.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BCD calendar RTC port - testbench
// Streams port writes, port reads and ticks into the clock, predicts every
// reply from a local calendar model and checks each reply beat in order.
// Phases change the prescaler divisor between runs: 65536, maximum, zero
// (saturation and pay-off) and a tick soak to carry into the next minute.
// ----------------------------------------------------------------------------

module tb_bcd_calendar_rtc_port;

    localparam logic [1:0] FUNC_NONE = 2'd3;

    typedef struct {
        logic [1:0]  func;
        logic [7:0]  addr;
        logic [7:0]  wdata;
        logic [15:0] cycles;
        logic        peek;
        int          gap;
    } port_access_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       second_elapsed;
    } rtc_reply_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // addr, write_data, cycles
    logic [2:0]  s_tuser = '0;   // func, peek
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;        // read_data
    logic [0:0]  m_tuser;        // second_elapsed
    logic        cfg_wen = 1'b0;
    logic [21:0] cfg_wdata = '0;

    bcd_calendar_rtc_port dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    always #1 clk = ~clk;

    // calendar model state
    bcrtc_pkg::rtc_time_t        clock_now;
    logic [bcrtc_pkg::ACC_W-1:0] prescale_acc;
    logic [bcrtc_pkg::ACC_W-1:0] sec_divisor;
    logic [4:0]                  cmd_reg;
    logic [7:0]                  xfer_buf [7];
    logic [2:0]                  xfer_idx;
    logic [2:0]                  xfer_cnt;

    port_access_t pending_accesses [$];
    rtc_reply_t   due_replies [$];
    int           beats_queued = 0;
    int           replies_seen = 0;
    int           mismatch_count = 0;
    int           send_calm = 0;
    bit           send_eager = 1'b0;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("%0t mismatch: %s", $time, what);
    endtask

    // {wrapped, next value}
    function automatic logic [8:0] bcd_inc(input logic [7:0] v, input logic [7:0] lim,
                                           input logic [7:0] wrap_to);
        logic [7:0] n;
        n = v;
        if (v[3:0] >= 4'h9 && v[3:0] != 4'hF)
            n = (v[7:4] >= 4'h9) ? 8'h00 : {v[7:4] + 4'd1, 4'h0};
        else
            n[3:0] = v[3:0] + 4'd1;
        return (n >= lim) ? {1'b1, wrap_to} : {1'b0, n};
    endfunction

    task automatic advance_clock_second();
        logic [8:0] r;
        logic [7:0] mday_limit;
        r = bcd_inc(clock_now.seconds, 8'h60, 8'h00);
        clock_now.seconds = r[7:0];
        if (!r[8])
            return;
        r = bcd_inc(clock_now.minutes, 8'h60, 8'h00);
        clock_now.minutes = r[7:0];
        if (!r[8])
            return;
        r = bcd_inc(clock_now.hours, 8'h24, 8'h00);
        clock_now.hours = r[7:0];
        if (!r[8])
            return;
        mday_limit = 8'h32;
        if (clock_now.month == 8'h01)
            mday_limit = (clock_now.year[1:0] == (clock_now.year[4] ? 2'd2 : 2'd0))
                         ? 8'h30 : 8'h29;
        else if (clock_now.month == 8'h03 || clock_now.month == 8'h05 ||
                 clock_now.month == 8'h08 || clock_now.month == 8'h10)
            mday_limit = 8'h31;
        r = bcd_inc(clock_now.wday, 8'h07, 8'h00);
        clock_now.wday = r[7:0];
        r = bcd_inc(clock_now.mday, mday_limit, 8'h01);
        clock_now.mday = r[7:0];
        if (r[8])
        begin
            r = bcd_inc(clock_now.month, 8'h12, 8'h00);
            clock_now.month = r[7:0];
            if (r[8])
            begin
                r = bcd_inc(clock_now.year, 8'hA0, 8'h00);
                clock_now.year = r[7:0];
            end
        end
    endtask

    task automatic reset_calendar_model();
        clock_now    = '{year: 8'h00, month: 8'h00, mday: 8'h01, wday: 8'h00,
                         hours: 8'h00, minutes: 8'h00, seconds: 8'h00};
        prescale_acc = '0;
        sec_divisor  = bcrtc_pkg::DIVISOR_RESET;
        cmd_reg      = '0;
        xfer_idx     = '0;
        xfer_cnt     = '0;
        for (int i = 0; i < 7; i++)
            xfer_buf[i] = '0;
    endtask

    task automatic predict_access(input port_access_t a);
        rtc_reply_t  r;
        logic [23:0] sum;
        r = '0;
        case (a.func)
            bcrtc_pkg::FUNC_WRITE:
            begin
                if (a.addr == bcrtc_pkg::PORT_CMD)
                begin
                    cmd_reg = a.wdata[4:0] & bcrtc_pkg::CMD_MASK;
                    if (cmd_reg == bcrtc_pkg::CMD_READ_TIME)
                    begin
                        for (int i = 0; i < 7; i++)
                            xfer_buf[i] = clock_now[8*(6-i) +: 8];
                        xfer_idx = '0;
                        xfer_cnt = bcrtc_pkg::XFER_LEN;
                    end
                    else if (cmd_reg == bcrtc_pkg::CMD_WRITE_TIME)
                    begin
                        xfer_idx = '0;
                        xfer_cnt = bcrtc_pkg::XFER_LEN;
                    end
                end
                else if (a.addr == bcrtc_pkg::PORT_DATA &&
                         cmd_reg == bcrtc_pkg::CMD_WRITE_TIME &&
                         xfer_idx < xfer_cnt && xfer_idx < bcrtc_pkg::XFER_LEN)
                begin
                    xfer_buf[xfer_idx] = a.wdata;
                    xfer_idx++;
                end
            end
            bcrtc_pkg::FUNC_READ:
            begin
                if (a.addr == bcrtc_pkg::PORT_CMD)
                    r.read_data = {3'b000, cmd_reg} | bcrtc_pkg::READ_FLAG;
                else if (a.addr == bcrtc_pkg::PORT_DATA)
                begin
                    r.read_data = bcrtc_pkg::READ_FLAG;
                    if (cmd_reg == bcrtc_pkg::CMD_READ_TIME && xfer_idx < xfer_cnt &&
                        xfer_idx < bcrtc_pkg::XFER_LEN)
                    begin
                        r.read_data = xfer_buf[xfer_idx];
                        if (!a.peek)
                            xfer_idx++;
                    end
                end
            end
            bcrtc_pkg::FUNC_TICK:
            begin
                sum = {2'b00, prescale_acc} + {8'h00, a.cycles};
                if (sum >= {2'b00, sec_divisor})
                begin
                    sum = sum - {2'b00, sec_divisor};
                    advance_clock_second();
                    r.second_elapsed = 1'b1;
                end
                if (sum > {2'b00, bcrtc_pkg::ACC_MAX})
                    sum = {2'b00, bcrtc_pkg::ACC_MAX};
                prescale_acc = sum[bcrtc_pkg::ACC_W-1:0];
            end
            default:
            begin
            end
        endcase
        due_replies.push_back(r);
    endtask

    task automatic check_reply(input logic [7:0] data, input logic sec);
        rtc_reply_t want;
        if (due_replies.size() == 0)
        begin
            report_mismatch($sformatf("reply beat with nothing expected (data %h)", data));
            return;
        end
        want = due_replies.pop_front();
        if (data !== want.read_data)
            report_mismatch($sformatf("read_data %h, expected %h", data, want.read_data));
        if (sec !== want.second_elapsed)
            report_mismatch($sformatf("second_elapsed %b, expected %b", sec,
                                      want.second_elapsed));
    endtask

    // sender
    port_access_t on_bus;
    int           send_wait;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            send_wait = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_access(on_bus);
            if (s_tvalid && !s_tready)
            begin
                // beat held until taken
            end
            else if (send_wait > 0)
            begin
                send_wait--;
                s_tvalid <= 1'b0;
            end
            else if (pending_accesses.size() > 0)
            begin
                on_bus = pending_accesses.pop_front();
                send_wait = on_bus.gap;
                s_tdata  <= {on_bus.cycles, on_bus.wdata, on_bus.addr};
                s_tuser  <= {on_bus.peek, on_bus.func};
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver
    int recv_wait;
    int recv_hold;
    int recv_calm;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            recv_wait = 0;
            recv_hold = 0;
            recv_calm = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                check_reply(m_tdata, m_tuser[0]);
                replies_seen++;
                if (replies_seen == 150 || replies_seen == 480)
                    recv_hold = 150;
                if (recv_calm > 0)
                begin
                    recv_calm--;
                    recv_wait = 0;
                end
                else
                begin
                    recv_wait = $urandom_range(0, 12);
                    if ($urandom_range(0, 19) == 0)
                        recv_calm = $urandom_range(20, 60);
                end
            end
            if (recv_hold > 0)
            begin
                recv_hold--;
                m_tready <= 1'b0;
            end
            else if (recv_wait > 0)
            begin
                recv_wait--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic push_access(input logic [1:0] f, input logic [7:0] a, input logic [7:0] d,
                               input logic [15:0] c, input logic p);
        port_access_t x;
        x = '{func: f, addr: a, wdata: d, cycles: c, peek: p, gap: 0};
        if (!send_eager)
        begin
            if (send_calm > 0)
                send_calm--;
            else
            begin
                x.gap = $urandom_range(0, 12);
                if ($urandom_range(0, 19) == 0)
                    send_calm = $urandom_range(20, 60);
            end
        end
        pending_accesses.push_back(x);
        beats_queued++;
    endtask

    task automatic push_tick(input logic [15:0] c);
        push_access(bcrtc_pkg::FUNC_TICK, 8'($urandom), 8'($urandom), c, 1'($urandom));
    endtask

    task automatic push_snapshot_read();
        push_access(bcrtc_pkg::FUNC_WRITE, bcrtc_pkg::PORT_CMD,
                    {3'($urandom), bcrtc_pkg::CMD_READ_TIME}, 16'($urandom), 1'($urandom));
        for (int i = 0; i < 7; i++)
            push_access(bcrtc_pkg::FUNC_READ, bcrtc_pkg::PORT_DATA, 8'($urandom),
                        16'($urandom), 1'b0);
    endtask

    function automatic logic [7:0] pick_addr();
        case ($urandom_range(0, 3))
            0: return bcrtc_pkg::PORT_CMD;
            1: return bcrtc_pkg::PORT_DATA;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic queue_random_burst();
        int n;
        case ($urandom_range(0, 9))
            0, 1, 2:
            begin
                push_access(bcrtc_pkg::FUNC_WRITE, bcrtc_pkg::PORT_CMD,
                            {3'($urandom), bcrtc_pkg::CMD_READ_TIME},
                            16'($urandom), 1'($urandom));
                n = $urandom_range(5, 9);
                for (int i = 0; i < n; i++)
                    if ($urandom_range(0, 5) == 0)
                        push_tick(16'($urandom_range(40000, 65535)));
                    else
                        push_access(bcrtc_pkg::FUNC_READ, bcrtc_pkg::PORT_DATA, 8'($urandom),
                                    16'($urandom), $urandom_range(0, 3) == 0);
            end
            3, 4:
            begin
                push_access(bcrtc_pkg::FUNC_WRITE, bcrtc_pkg::PORT_CMD,
                            {3'($urandom), bcrtc_pkg::CMD_WRITE_TIME},
                            16'($urandom), 1'($urandom));
                n = $urandom_range(5, 9);
                for (int i = 0; i < n; i++)
                    if ($urandom_range(0, 6) == 0)
                        push_access(bcrtc_pkg::FUNC_READ, bcrtc_pkg::PORT_CMD, 8'($urandom),
                                    16'($urandom), 1'($urandom));
                    else
                        push_access(bcrtc_pkg::FUNC_WRITE, bcrtc_pkg::PORT_DATA, 8'($urandom),
                                    16'($urandom), 1'($urandom));
            end
            5, 6, 7:
            begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    push_tick(($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                           : 16'($urandom_range(40000, 65535)));
            end
            8:
            begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++)
                    push_access(2'($urandom), pick_addr(), 8'($urandom), 16'($urandom),
                                1'($urandom));
            end
            default:
            begin
                push_access(bcrtc_pkg::FUNC_WRITE, bcrtc_pkg::PORT_CMD, 8'($urandom),
                            16'($urandom), 1'($urandom));
                push_access(bcrtc_pkg::FUNC_READ, bcrtc_pkg::PORT_CMD, 8'($urandom),
                            16'($urandom), 1'($urandom));
                push_access(bcrtc_pkg::FUNC_READ, bcrtc_pkg::PORT_DATA, 8'($urandom),
                            16'($urandom), 1'($urandom));
            end
        endcase
    endtask

    task automatic queue_random_run(input int count);
        int first;
        first = beats_queued;
        while (beats_queued - first < count)
            queue_random_burst();
    endtask

    // every beat gives one reply, so equal counts means the block is empty
    task automatic wait_drained();
        while (replies_seen != beats_queued)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_divisor(input logic [21:0] v);
        wait_drained();
        @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= v;
        sec_divisor = v;
        @(posedge clk);
        cfg_wen <= 1'b0;
    endtask

    initial
    begin
        reset_calendar_model();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset divisor
        push_access(bcrtc_pkg::FUNC_READ,  bcrtc_pkg::PORT_CMD,  8'h00, 16'h0000, 1'b0);
        push_access(bcrtc_pkg::FUNC_READ,  bcrtc_pkg::PORT_DATA, 8'hFF, 16'hFFFF, 1'b0);
        push_access(bcrtc_pkg::FUNC_READ,  8'h00,                8'h00, 16'h0000, 1'b1);
        push_access(bcrtc_pkg::FUNC_WRITE, bcrtc_pkg::PORT_DATA, 8'hFF, 16'h0000, 1'b0);
        push_access(bcrtc_pkg::FUNC_WRITE, bcrtc_pkg::PORT_CMD,
                    {3'b111, bcrtc_pkg::CMD_READ_TIME}, 16'hFFFF, 1'b1);
        push_access(bcrtc_pkg::FUNC_READ,  bcrtc_pkg::PORT_CMD,  8'h00, 16'h0000, 1'b0);
        push_access(bcrtc_pkg::FUNC_READ,  bcrtc_pkg::PORT_DATA, 8'h00, 16'h0000, 1'b1);
        for (int i = 0; i < 8; i++)
            push_access(bcrtc_pkg::FUNC_READ, bcrtc_pkg::PORT_DATA, 8'h00, 16'h0000, 1'b0);
        push_access(bcrtc_pkg::FUNC_WRITE, bcrtc_pkg::PORT_CMD,
                    {3'b000, bcrtc_pkg::CMD_WRITE_TIME}, 16'h0000, 1'b0);
        push_access(bcrtc_pkg::FUNC_WRITE, bcrtc_pkg::PORT_DATA, 8'hAA, 16'h0000, 1'b0);
        push_access(bcrtc_pkg::FUNC_WRITE, bcrtc_pkg::PORT_DATA, 8'h55, 16'h0000, 1'b1);
        push_access(bcrtc_pkg::FUNC_READ,  bcrtc_pkg::PORT_DATA, 8'h00, 16'h0000, 1'b0);
        push_tick(16'hFFFF);
        push_tick(16'h0000);
        push_access(FUNC_NONE,             8'hFF,                8'hFF, 16'hFFFF, 1'b1);
        push_access(bcrtc_pkg::FUNC_WRITE, 8'hFF,                8'hFF, 16'hFFFF, 1'b1);
        push_access(bcrtc_pkg::FUNC_READ,  8'hFF,                8'hFF, 16'hFFFF, 1'b0);
        push_access(bcrtc_pkg::FUNC_WRITE, bcrtc_pkg::PORT_CMD,  8'h1F, 16'h0000, 1'b0);
        push_access(bcrtc_pkg::FUNC_READ,  bcrtc_pkg::PORT_CMD,  8'h00, 16'h0000, 1'b0);

        write_divisor(22'd65536);
        queue_random_run(150);

        // build the prescaler up to just under the top
        write_divisor(bcrtc_pkg::ACC_MAX);
        for (int i = 0; i < 64; i++)
            push_tick(16'hFFFF);
        push_snapshot_read();

        // zero divisor: a second per tick and the prescaler saturates
        write_divisor(22'd0);
        for (int i = 0; i < 10; i++)
            push_tick(16'hFFFF);
        push_snapshot_read();

        // excess is paid off a second per tick
        write_divisor(bcrtc_pkg::DIVISOR_RESET);
        queue_random_run(150);

        // soak: enough back-to-back seconds to carry into the next minute
        write_divisor(22'd0);
        send_eager = 1'b1;
        for (int i = 0; i < 120; i++)
        begin
            push_tick(16'($urandom));
            if (i % 60 == 59)
                push_snapshot_read();
        end
        push_snapshot_read();
        send_eager = 1'b0;

        write_divisor(22'($urandom_range(65536, 200000)));
        queue_random_run(150);

        wait_drained();
        repeat (10) @(posedge clk);
        if (due_replies.size() != 0)
            report_mismatch($sformatf("%0d replies never arrived", due_replies.size()));
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
